### design/bcp_pkg.sv
// ----------------------------------------------------------------------------
// bcp_pkg: shared types and constants for the Bezier curve point generator
// Fixed-point formats for the curve parameter, weights and coordinates.
// ----------------------------------------------------------------------------
`default_nettype none
package bcp_pkg;

	localparam int T_FRAC_BITS = 16;
	localparam int T_W         = T_FRAC_BITS + 1;     // t and u reach 1.0
	localparam int SEG_W       = 6;
	localparam int COORD_W     = 32;
	localparam int PROD_W      = T_W + 1 + COORD_W;   // signed weight x coordinate
	localparam int SUM_W       = PROD_W + 2;          // four terms
	localparam int DIV_STEPS   = T_W;

	localparam logic [T_W-1:0]   T_ONE       = T_W'(1) << T_FRAC_BITS;
	localparam logic [SEG_W-1:0] SEG_RESET   = SEG_W'(16);

	typedef logic [T_W-1:0]            tpar_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [SEG_W-1:0]          seg_t;

	// Eight coordinates in input order: start, ctrl1, ctrl2, end (x then y)
	typedef coord_t curve_t [8];

endpackage
`default_nettype wire

### design/bezier_curve_points.sv
// ----------------------------------------------------------------------------
// bezier_curve_points: quadratic / cubic Bezier point generator
// Emits segment_count+1 points per curve through a six-stage pipeline.
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata 256b coords, tuser is_cubic
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata 64b point, tlast last_point
// cfg       in         cfg_valid / cfg_ready          cfg_data segment_count
//
// A curve yields n+1 points at the point generator (n = clamped segment_count), one
// point a cycle while m_axis is not stalled, and the earlier stages drain before the
// next curve's coordinates are latched. After reset and after every cfg write a
// serial divider works out 2^16 / n, and no curve is taken meanwhile.
// A stall at m_axis freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module bezier_curve_points (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
	input  wire logic [255:0] s_axis_tdata,
	// is_cubic
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// point_x, point_y
	output logic [63:0]       m_axis_tdata,
	output logic              m_axis_tlast,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [5:0]   cfg_data
);

	localparam int TW = bcp_pkg::T_W;
	localparam int FB = bcp_pkg::T_FRAC_BITS;

	// configuration and the t step divider
	bcp_pkg::seg_t   seg_q;
	bcp_pkg::seg_t   n_cur;
	logic [4:0]      div_cnt_q;
	logic [6:0]      div_rem_q;
	bcp_pkg::tpar_t  div_quo_q;
	logic [6:0]      div_trial;
	logic            div_busy;
	bcp_pkg::tpar_t  step_q_q;
	logic [5:0]      step_r_q;

	assign cfg_ready = 1'b1;
	assign n_cur     = (seg_q == '0) ? bcp_pkg::SEG_W'(1) : seg_q;
	assign div_busy  = (div_cnt_q != '0);
	assign div_trial = {div_rem_q[5:0], div_quo_q[TW-1]};

	// restoring division of 2^16 by n, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= bcp_pkg::SEG_RESET;
			div_cnt_q <= 5'(bcp_pkg::DIV_STEPS);
			div_rem_q <= '0;
			div_quo_q <= bcp_pkg::T_ONE;
			step_q_q  <= '0;
			step_r_q  <= '0;
		end else begin
			priority if (cfg_valid) begin
				seg_q     <= cfg_data;
				div_cnt_q <= 5'(bcp_pkg::DIV_STEPS);
				div_rem_q <= '0;
				div_quo_q <= bcp_pkg::T_ONE;
			end else if (div_busy) begin
				div_cnt_q <= div_cnt_q - 5'd1;
				if (div_trial >= {1'b0, n_cur}) begin
					div_rem_q <= div_trial - {1'b0, n_cur};
					div_quo_q <= {div_quo_q[TW-2:0], 1'b1};
				end else begin
					div_rem_q <= div_trial;
					div_quo_q <= {div_quo_q[TW-2:0], 1'b0};
				end
				if (div_cnt_q == 5'd1) begin
					// hold the finished step for the point generator
					step_q_q <= (div_trial >= {1'b0, n_cur}) ? {div_quo_q[TW-2:0], 1'b1}
						: {div_quo_q[TW-2:0], 1'b0};
					step_r_q <= (div_trial >= {1'b0, n_cur})
						? 6'(div_trial - {1'b0, n_cur}) : div_trial[5:0];
				end
			end else begin
				// idle: hold the step
			end
		end
	end

	// pipeline advance: the output register decides for every stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv;
	assign adv = !v_s6 || m_axis_tready;

	// latched curve
	bcp_pkg::curve_t curve_q;
	logic            cubic_q;
	logic            accept;

	// point generator
	logic           active_q;
	bcp_pkg::seg_t  idx_q;
	bcp_pkg::tpar_t t_q;
	logic [6:0]     r_q;
	logic [6:0]     r_next;
	logic           issue;
	logic           at_end;

	// take a curve only once the stages that still read the old one are empty
	assign s_axis_tready = !active_q && !div_busy && !v_s1 && !v_s2 && !v_s3;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign issue         = active_q && adv;
	assign at_end        = (idx_q == n_cur);
	assign r_next        = r_q + {1'b0, step_r_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 8; k++) begin
				curve_q[k] <= s_axis_tdata[k*32 +: 32];
			end
			cubic_q <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			t_q      <= '0;
			r_q      <= '0;
		end else begin
			priority if (accept) begin
				active_q <= 1'b1;
				idx_q    <= '0;
				t_q      <= '0;
				r_q      <= '0;
			end else if (issue) begin
				if (at_end) begin
					active_q <= 1'b0;
					idx_q    <= '0;
				end else begin
					idx_q <= idx_q + bcp_pkg::SEG_W'(1);
					// advance t by 2^16/n, carrying the remainder
					if (r_next >= {1'b0, n_cur}) begin
						r_q <= r_next - {1'b0, n_cur};
						t_q <= t_q + step_q_q + TW'(1);
					end else begin
						r_q <= r_next;
						t_q <= t_q + step_q_q;
					end
				end
			end else begin
				// idle or stalled: hold the generator
			end
		end
	end

	// stage 1: t, u
	bcp_pkg::tpar_t t_s1, u_s1;
	logic           last_s1, cubic_s1;
	// stage 2: squares and cross product
	bcp_pkg::tpar_t t_s2, u_s2, uu_s2, tt_s2;
	logic [2*TW-1:0] tu_s2;
	logic           last_s2, cubic_s2;
	// stage 3: Bernstein weights
	bcp_pkg::tpar_t w_s3 [4];
	logic           last_s3;
	// stage 4: products
	logic signed [bcp_pkg::PROD_W-1:0] p_s4 [8];
	logic           last_s4;
	// stage 5: sums
	logic signed [bcp_pkg::SUM_W-1:0] sum_s5 [2];
	logic           last_s5;
	// stage 6: output
	bcp_pkg::coord_t px_s6, py_s6;
	logic            last_s6;

	logic [2*TW-1:0] uu_full, tt_full, tu_full;
	logic [2*TW-1:0] cu_a, cu_b, cu_c, cu_d;
	logic [2*TW+1:0] cu_b3, cu_c3;
	bcp_pkg::tpar_t  w_next [4];
	logic signed [bcp_pkg::SUM_W-bcp_pkg::T_FRAC_BITS-1:0] sh [2];
	bcp_pkg::coord_t sat [2];

	assign uu_full = u_s1 * u_s1;
	assign tt_full = t_s1 * t_s1;
	assign tu_full = t_s1 * u_s1;
	assign cu_a    = uu_s2 * u_s2;
	assign cu_b    = t_s2 * uu_s2;
	assign cu_c    = tt_s2 * u_s2;
	assign cu_d    = tt_s2 * t_s2;
	assign cu_b3   = {2'b00, cu_b} + {1'b0, cu_b, 1'b0};
	assign cu_c3   = {2'b00, cu_c} + {1'b0, cu_c, 1'b0};

	always_comb begin
		if (cubic_s2) begin
			w_next[0] = cu_a[FB +: TW];
			w_next[1] = cu_b3[FB +: TW];
			w_next[2] = cu_c3[FB +: TW];
			w_next[3] = cu_d[FB +: TW];
		end else begin
			// quadratic: ctrl2 drops out
			w_next[0] = uu_s2;
			w_next[1] = tu_s2[FB-1 +: TW];
			w_next[2] = '0;
			w_next[3] = tt_s2;
		end
	end

	// floor by arithmetic shift, then clamp to 32 bits
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			sh[a] = sum_s5[a][bcp_pkg::SUM_W-1:FB];
			if (sh[a] > $signed({{(bcp_pkg::SUM_W-FB-32){1'b0}}, 32'h7FFF_FFFF})) begin
				sat[a] = 32'sh7FFF_FFFF;
			end else if (sh[a] < $signed({{(bcp_pkg::SUM_W-FB-32){1'b1}}, 32'h8000_0000}))
			begin
				sat[a] = 32'sh8000_0000;
			end else begin
				sat[a] = sh[a][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1     <= t_q;
			u_s1     <= bcp_pkg::T_ONE - t_q;
			last_s1  <= at_end;
			cubic_s1 <= cubic_q;

			t_s2     <= t_s1;
			u_s2     <= u_s1;
			uu_s2    <= uu_full[FB +: TW];
			tt_s2    <= tt_full[FB +: TW];
			tu_s2    <= tu_full;
			last_s2  <= last_s1;
			cubic_s2 <= cubic_s1;

			w_s3     <= w_next;
			last_s3  <= last_s2;

			for (int k = 0; k < 8; k++) begin
				p_s4[k] <= $signed({1'b0, w_s3[k/2]}) * curve_q[k];
			end
			last_s4 <= last_s3;

			for (int a = 0; a < 2; a++) begin
				sum_s5[a] <= bcp_pkg::SUM_W'(p_s4[a]) + bcp_pkg::SUM_W'(p_s4[2+a])
					+ bcp_pkg::SUM_W'(p_s4[4+a]) + bcp_pkg::SUM_W'(p_s4[6+a]);
			end
			last_s5 <= last_s4;

			px_s6   <= sat[0];
			py_s6   <= sat[1];
			last_s6 <= last_s5;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {py_s6, px_s6};
	assign m_axis_tlast  = last_s6;

	// a new curve starts the generator
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> active_q)
		else $error("curve accepted but generator not started");

	// the generator never runs on a half-finished step
	a_no_gen_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !div_busy)
		else $error("point generator running during division");

	// t lands exactly on one at the final point
	a_last_t_one: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && at_end) |-> (t_q == bcp_pkg::T_ONE))
		else $error("final point t is not one");

	// index never passes the segment count
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= n_cur))
		else $error("point index beyond segment count");

endmodule
`default_nettype wire
